/* rtl/hsd_pkg.sv */
// Package for the hi-res scan line pixel decoder.
// Holds the job descriptor type, colour code constants and the code swap function.
// No dependencies.
package hsd_pkg;

  localparam int PIX_MAX = 8;
  localparam int IDX_W   = 3;
  localparam int CODE_W  = 4;

  localparam logic [CODE_W-1:0] CODE_GREEN = 4'd8;
  localparam logic [CODE_W-1:0] CODE_BLACK = 4'd0;

  // index of the final pixel for each kind of byte
  localparam logic [IDX_W-1:0] LAST_MONO   = 3'd6;
  localparam logic [IDX_W-1:0] LAST_FIRST  = 3'd5;
  localparam logic [IDX_W-1:0] LAST_SECOND = 3'd7;

  localparam int PAL_BIT  = 7;
  localparam int HOLD_BIT = 6;

  typedef struct packed {
    logic [IDX_W-1:0]                  last_idx;
    logic [PIX_MAX-1:0][CODE_W-1:0]    codes;
  } job_t;

  // pixel values 1 and 2 trade places inside a palette
  function automatic logic [1:0] swap12(input logic [1:0] v);
    logic [1:0] r;
    case (v)
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd1;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* rtl/hsd_if.sv */
// Stream interfaces of the hi-res scan line pixel decoder.
// Byte channel in, pixel channel out. No dependencies.
interface hsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] video_byte;
  logic       line_start;

  modport source(output valid, video_byte, line_start, input ready);
  modport sink(input valid, video_byte, line_start, output ready);
endinterface

interface hsd_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] color;
  logic       last;

  modport source(output valid, color, last, input ready);
  modport sink(input valid, color, last, output ready);
endinterface

/* rtl/hsd_front.sv */
// Front end: accepts video bytes, tracks pair phase and held bit,
// and builds a pixel job for the queue. Uses hsd_pkg and hsd_byte_if.
module hsd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  hsd_byte_if.sink          bytes,
  input  logic              q_full,
  output logic              q_push,
  output hsd_pkg::job_t     q_job
);

  logic color_mode;
  logic pair_phase;
  logic held_bit;
  logic pair_phase_next;
  logic held_bit_next;
  logic first_byte;

  assign bytes.ready = !q_full;
  assign q_push      = bytes.valid && !q_full;
  assign first_byte  = bytes.line_start || !pair_phase;

  always_comb begin
    logic [7:0] b;
    logic       pal;
    b               = bytes.video_byte;
    pal             = b[hsd_pkg::PAL_BIT];
    pair_phase_next = pair_phase;
    held_bit_next   = held_bit;
    q_job.codes     = '0;
    if (!color_mode) begin
      for (int j = 0; j < 7; j++) begin
        q_job.codes[j] = b[j] ? hsd_pkg::CODE_GREEN : hsd_pkg::CODE_BLACK;
      end
      q_job.last_idx  = hsd_pkg::LAST_MONO;
      pair_phase_next = 1'b0;
    end else if (first_byte) begin
      for (int j = 0; j < 3; j++) begin
        q_job.codes[2*j]   = {1'b0, pal, hsd_pkg::swap12(b[2*j +: 2])};
        q_job.codes[2*j+1] = {1'b0, pal, hsd_pkg::swap12(b[2*j +: 2])};
      end
      q_job.last_idx  = hsd_pkg::LAST_FIRST;
      held_bit_next   = b[hsd_pkg::HOLD_BIT];
      pair_phase_next = 1'b1;
    end else begin
      // leading pixel joins the held bit of the first byte, unswapped
      q_job.codes[0] = {1'b0, pal, held_bit, b[0]};
      q_job.codes[1] = {1'b0, pal, held_bit, b[0]};
      for (int j = 0; j < 3; j++) begin
        q_job.codes[2*j+2] = {1'b0, pal, hsd_pkg::swap12(b[2*j+1 +: 2])};
        q_job.codes[2*j+3] = {1'b0, pal, hsd_pkg::swap12(b[2*j+1 +: 2])};
      end
      q_job.last_idx  = hsd_pkg::LAST_SECOND;
      pair_phase_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b1;
      pair_phase <= 1'b0;
      held_bit   <= 1'b0;
    end else begin
      if (cfg_we) color_mode <= cfg_wdata;
      if (q_push) begin
        pair_phase <= pair_phase_next;
        held_bit   <= held_bit_next;
      end
    end
  end

endmodule

/* rtl/hsd_queue.sv */
// Short job queue between front and back end.
// Register array with read and write pointers. Uses hsd_pkg.
module hsd_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hsd_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output hsd_pkg::job_t  head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hsd_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/hsd_back.sv */
// Back end: walks the head job into the output register one pixel per cycle
// unless the pixel channel stalls. Uses hsd_pkg and hsd_pix_if.
module hsd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  hsd_pkg::job_t  head_job,
  output logic           pop,
  hsd_pix_if.source      pixels
);

  logic [hsd_pkg::IDX_W-1:0]  idx;
  logic                       out_valid;
  logic [hsd_pkg::CODE_W-1:0] out_color;
  logic                       out_last;
  logic                       load;
  logic                       at_end;

  assign load   = head_valid && (!out_valid || pixels.ready);
  assign at_end = (idx == head_job.last_idx);
  assign pop    = load && at_end;

  assign pixels.valid = out_valid;
  assign pixels.color = out_color;
  assign pixels.last  = out_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_color <= head_job.codes[idx];
      out_last  <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load)              out_valid <= 1'b1;
      else if (pixels.ready) out_valid <= 1'b0;
      if (load) idx <= at_end ? '0 : idx + 1'b1;
    end
  end

endmodule

/* rtl/hires_scanline_pixel_decoder.sv */
// Hi-res scan line pixel decoder, top level.
// Uses hsd_pkg, hsd_if, hsd_front, hsd_queue and hsd_back.
//
// Video bytes enter on the byte channel and leave as one colour code per beat
// on the pixel channel, last set on the final pixel of each byte. The back end
// emits one pixel per cycle unless the pixel channel stalls; a byte gives 7
// pixels in monochrome mode and 6 or 8 in colour mode (first or second byte of
// a pair, 14 per pair), and that serializer sets the rate. The front end takes
// a new byte in any cycle the job queue (QUEUE_DEPTH entries) has room, so
// bytes queue up while pixels drain; the first pixel of a byte passes the job
// queue and then the output register before it is offered. color_mode resets
// to colour rendering and must only be written while the block is idle.
module hires_scanline_pixel_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  hsd_byte_if.sink   bytes,
  hsd_pix_if.source  pixels
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_head_valid;
  hsd_pkg::job_t q_job;
  hsd_pkg::job_t q_head_job;

  hsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bytes     (bytes),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  hsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  hsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .pixels     (pixels)
  );

endmodule

/* test/tb_hires_scanline_pixel_decoder.sv */
// Testbench for hires_scanline_pixel_decoder: drives video bytes, predicts pixel beats.
// Depends on hsd_pkg, hsd_if and the decoder top level from the rtl folder.
module tb_hires_scanline_pixel_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hsd_pkg::CODE_W-1:0] PAL_LOW  = 4'd0;
  localparam logic [hsd_pkg::CODE_W-1:0] PAL_HIGH = 4'd4;
  localparam logic              MODE_MONO  = 1'b0;
  localparam logic              MODE_COLOR = 1'b1;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_SHOWN    = 10;
  localparam int HOLD_LEN     = 150;

  typedef struct packed {
    logic [hsd_pkg::CODE_W-1:0] color;
    logic                       last;
  } pixel_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  hsd_byte_if byte_ch();
  hsd_pix_if  pix_ch();

  hires_scanline_pixel_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .bytes    (byte_ch),
    .pixels   (pix_ch)
  );

  // shadow of the decoder state
  logic mode_r  = MODE_COLOR;
  logic phase_r = 1'b0;
  logic held_r  = 1'b0;

  pixel_t pix_expect[$];
  pixel_t want;

  int err_cnt      = 0;
  int bytes_sent   = 0;
  int pix_checked  = 0;
  int mono_bytes   = 0;
  int first_bytes  = 0;
  int second_bytes = 0;
  int cfg_writes   = 0;
  int hold_cycles  = 0;
  bit src_idle_en  = 1'b1;
  bit sink_stall_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[hires_scanline_pixel_decoder] ERROR");
    $finish;
  end

  function automatic logic [1:0] trade_mid(input logic [1:0] v);
    logic [1:0] r;
    case (v)
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd1;
      default: r = v;
    endcase
    return r;
  endfunction

  // works out the pixel beats of one accepted byte and queues them
  function automatic void predict_pixels(input logic [7:0] b, input logic ls);
    logic [hsd_pkg::CODE_W-1:0] codes [hsd_pkg::PIX_MAX];
    logic [hsd_pkg::CODE_W-1:0] pal;
    pixel_t p;
    int n;
    int i;
    n = 0;
    if (mode_r == MODE_MONO) begin
      for (i = 0; i < 7; i++) codes[i] = b[i] ? hsd_pkg::CODE_GREEN : hsd_pkg::CODE_BLACK;
      n = 7;
      phase_r = 1'b0;
      mono_bytes++;
    end else begin
      pal = b[hsd_pkg::PAL_BIT] ? PAL_HIGH : PAL_LOW;
      if (ls || !phase_r) begin
        for (i = 0; i < 3; i++) begin
          codes[2*i]   = pal + trade_mid(b[2*i +: 2]);
          codes[2*i+1] = codes[2*i];
        end
        n = 6;
        held_r  = b[hsd_pkg::HOLD_BIT];
        phase_r = 1'b1;
        first_bytes++;
      end else begin
        // straddling pixel uses the raw value, no trade
        codes[0] = pal + {held_r, b[0]};
        codes[1] = codes[0];
        for (i = 0; i < 3; i++) begin
          codes[2*i+2] = pal + trade_mid(b[2*i+1 +: 2]);
          codes[2*i+3] = codes[2*i+2];
        end
        n = 8;
        phase_r = 1'b0;
        second_bytes++;
      end
    end
    for (i = 0; i < n; i++) begin
      p.color = codes[i];
      p.last  = (i == n - 1);
      pix_expect.push_back(p);
    end
  endfunction

  function automatic void report_error(input string what, input logic [4:0] exp_v,
                                       input logic [4:0] act_v);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endfunction

  // pixel receiver: random stall bursts plus one long hold-off on request
  initial begin
    pix_ch.ready = 1'b0;
    forever begin
      int stall_left;
      @(posedge clk);
      if (hold_cycles > 0) begin
        pix_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        pix_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
        pix_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        pix_ch.ready <= 1'b1;
      end
    end
  end

  // pixel checker
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pix_expect.size() == 0) begin
        report_error("pixel beat with nothing pending", 5'd0, {pix_ch.color, pix_ch.last});
      end else begin
        want = pix_expect.pop_front();
        pix_checked++;
        if (pix_ch.color !== want.color)
          report_error("color mismatch", {1'b0, want.color}, {1'b0, pix_ch.color});
        if (pix_ch.last !== want.last)
          report_error("last mismatch", {4'd0, want.last}, {4'd0, pix_ch.last});
      end
    end
  end

  // called at a clock edge; returns at the edge that took the byte
  task automatic send_byte(input logic [7:0] b, input logic ls);
    int gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.video_byte <= b;
    byte_ch.line_start <= ls;
    do @(posedge clk); while (!byte_ch.ready);
    predict_pixels(b, ls);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (pix_expect.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_r = m;
    cfg_writes++;
  endtask

  // lines of random length, line_start on the first byte; noise_pct of the
  // marks are randomized to break the pairing
  task automatic run_lines(input int n_bytes, input int noise_pct);
    int i;
    int left;
    logic ls;
    logic [7:0] b;
    left = 0;
    for (i = 0; i < n_bytes; i++) begin
      b = 8'($urandom_range(0, 255));
      if (left == 0) begin
        left = $urandom_range(1, 10);
        ls = 1'b1;
      end else begin
        ls = 1'b0;
      end
      if ($urandom_range(0, 99) < noise_pct) ls = 1'($urandom_range(0, 1));
      left--;
      send_byte(b, ls);
    end
  endtask

  task automatic test_color_directed();
    set_mode(MODE_COLOR);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // palette flips inside the pair, held bit set
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h15, 1'b0);
    send_byte(8'h2A, 1'b0);
    // line start where a first byte was due, then one where a second byte was due
    send_byte(8'h2A, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'hC0, 1'b0);
  endtask

  task automatic test_mono_directed();
    set_mode(MODE_MONO);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h80, 1'b1);
    // a mono byte between colour bytes restarts the pair
    set_mode(MODE_COLOR);
    send_byte(8'h7F, 1'b1);
    set_mode(MODE_MONO);
    send_byte(8'h3C, 1'b0);
    set_mode(MODE_COLOR);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_color_random();
    set_mode(MODE_COLOR);
    run_lines(50, 10);
  endtask

  task automatic test_mono_random();
    set_mode(MODE_MONO);
    run_lines(30, 30);
  endtask

  task automatic test_backpressure();
    set_mode(MODE_COLOR);
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    hold_cycles   = HOLD_LEN;
    run_lines(20, 0);
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  task automatic test_full_rate();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    set_mode(MODE_COLOR);
    run_lines(30, 10);
    set_mode(MODE_MONO);
    run_lines(10, 50);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.video_byte = 8'h00;
    byte_ch.line_start = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_color_directed();
    test_mono_directed();
    test_color_random();
    test_mono_random();
    test_backpressure();
    test_full_rate();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pix_expect.size() != 0) begin
      err_cnt += pix_expect.size();
      $display("%0d pixel beats never arrived", pix_expect.size());
    end
    $display("bytes %0d (mono %0d, first %0d, second %0d), pixel beats checked %0d",
             bytes_sent, mono_bytes, first_bytes, second_bytes, pix_checked);
    $display("mode writes %0d, mismatches %0d", cfg_writes, err_cnt);
    if (err_cnt == 0)
      $display("[hires_scanline_pixel_decoder] OK");
    else
      $display("[hires_scanline_pixel_decoder] ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/hsd_pkg.sv
rtl/hsd_if.sv
rtl/hsd_front.sv
rtl/hsd_queue.sv
rtl/hsd_back.sv
rtl/hires_scanline_pixel_decoder.sv
test/tb_hires_scanline_pixel_decoder.sv
